FILE: rtl/core/s5x_pkg.sv
// ----------------------------------------------------------------------------
// s5x_pkg: shared types and constants of the S5 sleep-type extractor
// Byte and result layouts, parse phases, AML codes and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package s5x_pkg;

  // AML codes of interest
  localparam logic [31:0] NAME_S5     = 32'h5F53_355F;  // "_S5_", oldest byte high
  localparam logic [7:0]  NAME_OP     = 8'h08;
  localparam logic [7:0]  PACKAGE_OP  = 8'h12;
  localparam logic [7:0]  BYTE_PREFIX = 8'h0A;
  localparam logic [7:0]  ROOT_CHAR   = 8'h5C;
  localparam int unsigned SLP_SHIFT   = 10;

  // Window of previous bytes kept by the parser (newest low)
  localparam int unsigned WIN_BYTES = 5;
  localparam int unsigned WIN_W     = 8 * WIN_BYTES;

  // Result queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_STRUCT = 2'd2,
    ST_TRUNC  = 2'd3
  } status_t;

  typedef enum logic [7:0] {
    PH_SEARCH = 8'b0000_0001,
    PH_PKG_OP = 8'b0000_0010,
    PH_PKGLEN = 8'b0000_0100,
    PH_SKIP   = 8'b0000_1000,
    PH_A_PRE  = 8'b0001_0000,
    PH_A      = 8'b0010_0000,
    PH_B_PRE  = 8'b0100_0000,
    PH_B      = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } s5x_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  sleep_type_a;
    logic [7:0]  sleep_type_b;
    logic [15:0] pm1_value_a;
    logic [15:0] pm1_value_b;
  } s5x_out_t;

  // Decided outcome handed from the parser to the back end
  typedef struct packed {
    status_t    status;
    logic [7:0] type_a;
    logic [7:0] type_b;
  } s5x_rec_t;

endpackage

`default_nettype wire

FILE: rtl/core/acpi_s5_sleep_type_extractor.sv
// ----------------------------------------------------------------------------
// acpi_s5_sleep_type_extractor: DSDT _S5_ sleep-type parser
// Scans a DSDT body byte stream for the _S5_ package and reports its two
// sleep-type values, one result per table.
//
//   channel  | direction | payload    | beat
//   ---------+-----------+------------+----------------------------------
//   item     | in        | s5x_in_t   | one table byte, last_byte on end
//   result   | out       | s5x_out_t  | one outcome per table
//
// One byte is taken every cycle while the queue has room; the parser decides
// each byte combinationally. A result passes the queue, then the output
// register. Synchronous reset clears parser, queue and output valid.
// A stalled result fills the two-entry queue; only then is item_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module acpi_s5_sleep_type_extractor
  import s5x_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  input  wire s5x_in_t  item,
  output logic          result_valid,
  input  wire logic     result_ready,
  output s5x_out_t      result
);

  logic     push;
  s5x_rec_t push_rec;
  logic     not_full;
  logic     rec_valid;
  s5x_rec_t rec;
  logic     pop;

  s5x_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .push        (push),
    .rec         (push_rec),
    .queue_ready (not_full)
  );

  s5x_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .not_full  (not_full),
    .pop_valid (rec_valid),
    .pop_rec   (rec),
    .pop       (pop)
  );

  s5x_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rec_valid    (rec_valid),
    .rec          (rec),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

FILE: rtl/core/s5x_front.sv
// ----------------------------------------------------------------------------
// s5x_front: byte parser
// Shifts each table byte into a window, walks the _S5_ package phases and
// posts at most one outcome record per table into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module s5x_front
  import s5x_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  input  wire s5x_in_t  item,
  output logic          push,
  output s5x_rec_t      rec,
  input  wire logic     queue_ready
);

  logic [WIN_W-1:0] win;
  phase_t           phase;
  logic [2:0]       skip_count;
  logic [7:0]       type_a;
  logic             sent;

  phase_t           phase_next;
  logic [2:0]       skip_count_next;
  logic [7:0]       type_a_next;
  logic [WIN_W+7:0] w;
  logic [7:0]       b;
  logic [7:0]       p1;
  logic [7:0]       p2;
  logic             emit;
  logic             accept;

  // Take a beat whenever the queue has room for its possible result
  assign item_ready = queue_ready;
  assign accept     = item_valid && queue_ready;
  assign b          = item.data_byte;
  assign w          = {win, b};
  assign p1         = w[39:32];
  assign p2         = w[47:40];

  // Decode the current byte against the parse phase
  always_comb begin
    phase_next      = phase;
    skip_count_next = skip_count;
    type_a_next     = type_a;
    emit            = 1'b0;
    rec.status      = ST_OK;
    rec.type_a      = 8'h00;
    rec.type_b      = 8'h00;
    if (!sent) begin
      unique case (phase)
        PH_SEARCH: begin
          if (w[31:0] == NAME_S5) begin
            if (p1 == NAME_OP || (p2 == NAME_OP && p1 == ROOT_CHAR)) begin
              phase_next = PH_PKG_OP;
            end else begin
              emit       = 1'b1;
              rec.status = ST_STRUCT;
            end
          end
        end
        PH_PKG_OP: begin
          if (b == PACKAGE_OP) begin
            phase_next = PH_PKGLEN;
          end else begin
            emit       = 1'b1;
            rec.status = ST_STRUCT;
          end
        end
        PH_PKGLEN: begin
          skip_count_next = {1'b0, b[7:6]} + 3'd1;
          phase_next      = PH_SKIP;
        end
        PH_SKIP: begin
          skip_count_next = skip_count - 3'd1;
          if (skip_count_next == 3'd0) begin
            phase_next = PH_A_PRE;
          end
        end
        PH_A_PRE: begin
          if (b == BYTE_PREFIX) begin
            phase_next = PH_A;
          end else begin
            type_a_next = b;
            phase_next  = PH_B_PRE;
          end
        end
        PH_A: begin
          type_a_next = b;
          phase_next  = PH_B_PRE;
        end
        PH_B_PRE: begin
          if (b == BYTE_PREFIX) begin
            phase_next = PH_B;
          end else begin
            emit       = 1'b1;
            rec.status = ST_OK;
            rec.type_a = type_a;
            rec.type_b = b;
          end
        end
        PH_B: begin
          emit       = 1'b1;
          rec.status = ST_OK;
          rec.type_a = type_a;
          rec.type_b = b;
        end
        default: begin
          phase_next = PH_SEARCH;
        end
      endcase
    end
    // Close out a table that ends without a decided outcome
    if (item.last_byte && !sent && !emit) begin
      emit       = 1'b1;
      rec.status = (phase_next == PH_SEARCH) ? ST_ABSENT : ST_TRUNC;
      rec.type_a = 8'h00;
      rec.type_b = 8'h00;
    end
  end

  assign push = accept && emit;

  // Advance parser state; the last byte clears it for the next table
  always_ff @(posedge clk) begin
    if (rst) begin
      win        <= '0;
      phase      <= PH_SEARCH;
      skip_count <= 3'd0;
      type_a     <= 8'h00;
      sent       <= 1'b0;
    end else if (accept) begin
      if (item.last_byte) begin
        win        <= '0;
        phase      <= PH_SEARCH;
        skip_count <= 3'd0;
        type_a     <= 8'h00;
        sent       <= 1'b0;
      end else if (!sent) begin
        win        <= w[WIN_W-1:0];
        phase      <= phase_next;
        skip_count <= skip_count_next;
        type_a     <= type_a_next;
        sent       <= emit;
      end
    end
  end

  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> (item_valid && item_ready))
    else $error("result posted without an accepted beat");

  a_one_per_table: assert property (@(posedge clk) disable iff (rst)
    (accept && sent && !item.last_byte) |-> !push)
    else $error("second result posted for one table");

  a_sent_after_push: assert property (@(posedge clk) disable iff (rst)
    (push && !item.last_byte) |=> sent)
    else $error("result flag not set after posting");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (accept && item.last_byte) |=> (phase == PH_SEARCH && !sent && win == '0))
    else $error("parser state not cleared at end of table");

endmodule

`default_nettype wire

FILE: rtl/core/s5x_queue.sv
// ----------------------------------------------------------------------------
// s5x_queue: result queue
// Small FIFO of outcome records that lets parser and output stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module s5x_queue
  import s5x_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire s5x_rec_t push_rec,
  output logic          not_full,
  output logic          pop_valid,
  output s5x_rec_t      pop_rec,
  input  wire logic     pop
);

  s5x_rec_t            entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign not_full  = (count != QCNT_W'(QDEPTH));
  assign pop_valid = (count != '0);
  assign pop_rec   = entries[rd_ptr];
  assign do_push   = push && not_full;
  assign do_pop    = pop && pop_valid;

  // Store records at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/s5x_back.sv
// ----------------------------------------------------------------------------
// s5x_back: result formatter
// Pulls outcome records from the queue, forms the PM1 control values and
// holds the finished result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module s5x_back
  import s5x_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     rec_valid,
  input  wire s5x_rec_t rec,
  output logic          pop,
  output logic          result_valid,
  input  wire logic     result_ready,
  output s5x_out_t      result
);

  s5x_out_t result_next;

  // Load when the output register is empty or being drained
  assign pop = rec_valid && (!result_valid || result_ready);

  always_comb begin
    result_next.status       = rec.status;
    result_next.sleep_type_a = rec.type_a;
    result_next.sleep_type_b = rec.type_b;
    result_next.pm1_value_a  = {rec.type_a[5:0], 10'b0};
    result_next.pm1_value_b  = {rec.type_b[5:0], 10'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: bench/s5_outcome_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s5_outcome_checker: result checker for the S5 sleep-type extractor
// Watches the byte and result channels. Each accepted byte runs through a
// local copy of the _S5_ parser. Each predicted outcome is queued, and every
// result beat is compared field by field with the oldest queued outcome.
// ----------------------------------------------------------------------------

module s5_outcome_checker
  import s5x_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  logic     item_ready,
  input  s5x_in_t  item,
  input  logic     result_valid,
  input  logic     result_ready,
  input  s5x_out_t result,
  output int       errors,
  output int       pending
);

  // Parser state as seen by the prediction
  logic [47:0] recent_bytes;
  phase_t      parse_phase;
  logic [2:0]  bytes_to_skip;
  logic [7:0]  first_type;
  logic        outcome_given;

  s5x_out_t    outcome_queue[$];
  int          mismatch_count = 0;

  assign errors = mismatch_count;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("%0t: result mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  function automatic s5x_out_t make_outcome(status_t st, logic [7:0] a, logic [7:0] b);
    s5x_out_t o;
    o.status       = st;
    o.sleep_type_a = a;
    o.sleep_type_b = b;
    o.pm1_value_a  = 16'(a) << SLP_SHIFT;
    o.pm1_value_b  = 16'(b) << SLP_SHIFT;
    return o;
  endfunction

  task automatic clear_table();
    recent_bytes  = '0;
    parse_phase   = PH_SEARCH;
    bytes_to_skip = '0;
    first_type    = '0;
    outcome_given = 1'b0;
  endtask

  // Advance the parser by one table byte and queue the outcome it decides
  task automatic take_byte(logic [7:0] b, logic last);
    s5x_out_t o;
    logic     decided;
    logic [7:0] pre1;
    logic [7:0] pre2;
    decided = 1'b0;
    o = '0;
    if (!outcome_given) begin
      recent_bytes = {recent_bytes[39:0], b};
      case (parse_phase)
        PH_SEARCH: begin
          if (recent_bytes[31:0] == NAME_S5) begin
            pre1 = recent_bytes[39:32];
            pre2 = recent_bytes[47:40];
            if (pre1 == NAME_OP || (pre2 == NAME_OP && pre1 == ROOT_CHAR)) begin
              parse_phase = PH_PKG_OP;
            end else begin
              o = make_outcome(ST_STRUCT, 8'h00, 8'h00);
              decided = 1'b1;
            end
          end
        end
        PH_PKG_OP: begin
          if (b == PACKAGE_OP) begin
            parse_phase = PH_PKGLEN;
          end else begin
            o = make_outcome(ST_STRUCT, 8'h00, 8'h00);
            decided = 1'b1;
          end
        end
        PH_PKGLEN: begin
          // lead byte, then its extra length bytes plus the element count
          bytes_to_skip = {1'b0, b[7:6]} + 3'd1;
          parse_phase   = PH_SKIP;
        end
        PH_SKIP: begin
          bytes_to_skip = bytes_to_skip - 3'd1;
          if (bytes_to_skip == 3'd0) parse_phase = PH_A_PRE;
        end
        PH_A_PRE: begin
          if (b == BYTE_PREFIX) begin
            parse_phase = PH_A;
          end else begin
            first_type  = b;
            parse_phase = PH_B_PRE;
          end
        end
        PH_A: begin
          first_type  = b;
          parse_phase = PH_B_PRE;
        end
        PH_B_PRE: begin
          if (b == BYTE_PREFIX) begin
            parse_phase = PH_B;
          end else begin
            o = make_outcome(ST_OK, first_type, b);
            decided = 1'b1;
          end
        end
        default: begin
          o = make_outcome(ST_OK, first_type, b);
          decided = 1'b1;
        end
      endcase
      if (decided) outcome_given = 1'b1;
    end
    // Close the table on its last byte
    if (last) begin
      if (!outcome_given) begin
        o = make_outcome(parse_phase == PH_SEARCH ? ST_ABSENT : ST_TRUNC, 8'h00, 8'h00);
        decided = 1'b1;
      end
      clear_table();
    end
    if (decided) outcome_queue.push_back(o);
  endtask

  // Compare one result beat with the oldest outcome
  task automatic check_result(s5x_out_t got);
    s5x_out_t want;
    if (outcome_queue.size() == 0) begin
      report_mismatch($sformatf("unexpected result 0x%0h", got));
    end else begin
      want = outcome_queue.pop_front();
      check_field("status", 16'(got.status), 16'(want.status));
      check_field("sleep_type_a", 16'(got.sleep_type_a), 16'(want.sleep_type_a));
      check_field("sleep_type_b", 16'(got.sleep_type_b), 16'(want.sleep_type_b));
      check_field("pm1_value_a", got.pm1_value_a, want.pm1_value_a);
      check_field("pm1_value_b", got.pm1_value_b, want.pm1_value_b);
    end
  endtask

  // Predict first, then compare, so a same-edge result never races its byte
  always @(posedge clk) begin
    if (rst) begin
      clear_table();
      outcome_queue.delete();
    end else begin
      if (item_valid && item_ready) take_byte(item.data_byte, item.last_byte);
      if (result_valid && result_ready) check_result(result);
    end
    pending <= outcome_queue.size();
  end

endmodule

FILE: bench/acpi_s5_sleep_type_extractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpi_s5_sleep_type_extractor_tb: stimulus and verdict for the S5 extractor
// Streams short DSDT bodies, directed corner cases first, then random tables
// that are mostly well-formed _S5_ packages, in bursts with random gaps. The
// result side stalls on its own pattern, with one long hold-off to fill the
// block. Checking is left to s5_outcome_checker.
// ----------------------------------------------------------------------------

module acpi_s5_sleep_type_extractor_tb;
  import s5x_pkg::*;

  localparam int TARGET_BYTES  = 400;
  localparam int TARGET_TABLES = 20;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 16;

  logic     clk;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_ready;
  s5x_in_t  item = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  s5x_out_t result;

  int       errors;
  int       pending;
  int       cycle_count = 0;

  logic [7:0] table_bytes[$];
  int         bytes_sent = 0;
  int         tables_sent = 0;
  int         burst_left = 8;
  logic       gaps_on = 1'b0;

  acpi_s5_sleep_type_extractor dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  s5_outcome_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("acpi_s5_sleep_type_extractor test failed");
      $finish;
    end
  end

  // Stall the result side; hold off once for a long stretch to fill the queue
  initial begin : result_stall
    int mode;
    int span;
    int elapsed;
    logic held;
    elapsed = 0;
    held = 1'b0;
    wait (!rst);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 60);
      repeat (span) begin
        case (mode)
          0: result_ready <= 1'b1;
          1: result_ready <= 1'($urandom_range(0, 1));
          default: result_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
        elapsed++;
      end
      if (!held && elapsed >= 150) begin
        result_ready <= 1'b0;
        repeat (200) @(posedge clk);
        held = 1'b1;
      end
    end
  end

  // Offer one byte and hold it until accepted; end bursts with a random gap
  task automatic offer_byte(logic [7:0] b, logic last);
    int gap;
    item_valid <= 1'b1;
    item       <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!item_ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 5) == 0) gaps_on = !gaps_on;
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_table();
    for (int i = 0; i < table_bytes.size(); i++) begin
      offer_byte(table_bytes[i], i == table_bytes.size() - 1);
    end
    bytes_sent += table_bytes.size();
    tables_sent++;
  endtask

  task automatic push_random(int n);
    repeat (n) table_bytes.push_back(8'($urandom));
  endtask

  // Build a random table: mostly a well-formed _S5_ package with random content
  task automatic build_table();
    int kind;
    int cut;
    logic [7:0] lead;
    table_bytes.delete();
    kind = $urandom_range(0, 9);
    push_random($urandom_range(0, 5));
    if (kind == 0) begin
      // plain noise, usually no name at all
      push_random($urandom_range(1, 12));
    end else begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3: table_bytes.push_back(NAME_OP);
        4, 5: begin
          table_bytes.push_back(NAME_OP);
          table_bytes.push_back(ROOT_CHAR);
        end
        6: table_bytes.push_back(ROOT_CHAR);
        default: push_random(1);
      endcase
      table_bytes.push_back(NAME_S5[31:24]);
      table_bytes.push_back(NAME_S5[23:16]);
      table_bytes.push_back(NAME_S5[15:8]);
      table_bytes.push_back(NAME_S5[7:0]);
      if ($urandom_range(0, 9) == 0) push_random(1);
      else table_bytes.push_back(PACKAGE_OP);
      lead = 8'($urandom);
      table_bytes.push_back(lead);
      push_random(int'(lead[7:6]) + 1);
      if ($urandom_range(0, 1) == 1) table_bytes.push_back(BYTE_PREFIX);
      push_random(1);
      if ($urandom_range(0, 1) == 1) table_bytes.push_back(BYTE_PREFIX);
      push_random(1);
      push_random($urandom_range(0, 3));
      // cut the table short somewhere
      if (kind == 1) begin
        cut = $urandom_range(1, table_bytes.size() - 1);
        while (table_bytes.size() > cut) table_bytes.delete(table_bytes.size() - 1);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Name at table start with no prefix, ending on the last byte
    table_bytes = '{8'h5F, 8'h53, 8'h35, 8'h5F};
    send_table();
    // Table with no name
    table_bytes = '{8'hFF};
    send_table();
    // Good prefix, table ends right after the name
    table_bytes = '{8'h08, 8'h5F, 8'h53, 8'h35, 8'h5F};
    send_table();
    // Wrong package opcode on the last byte
    table_bytes = '{8'h08, 8'h5F, 8'h53, 8'h35, 8'h5F, 8'h13};
    send_table();
    // Rooted name, byte prefixes on both types, extreme type values
    table_bytes = '{8'h08, 8'h5C, 8'h5F, 8'h53, 8'h35, 8'h5F, 8'h12, 8'h00, 8'h02,
                    8'h0A, 8'hFF, 8'h0A, 8'h80};
    send_table();

    while (bytes_sent < TARGET_BYTES || tables_sent < TARGET_TABLES) begin
      build_table();
      send_table();
    end
    item_valid <= 1'b0;

    // Drain outstanding results, then linger past the output latency
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("acpi_s5_sleep_type_extractor test passed");
    end else begin
      $display("acpi_s5_sleep_type_extractor test failed");
    end
    $finish;
  end

endmodule
